// ===== rtl/wtrs_pkg.sv =====
package wtrs_pkg;

  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned RATIO_W  = 7;
  // weight times a share of at most one hundred
  localparam int unsigned PROD_W   = WEIGHT_W + RATIO_W;
  // difference of two products, signed
  localparam int unsigned DIFF_W   = PROD_W + 1;
  localparam int unsigned ERR_W    = 64;
  // twice the error near zero plus the difference, with headroom
  localparam int unsigned CMP_W    = 44;

  localparam logic [RATIO_W-1:0] RATIO_FULL  = 7'd100;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 7'd50;

  localparam logic signed [ERR_W-1:0] ERR_BOUND = 64'sd1 <<< 40;
  localparam logic signed [ERR_W-1:0] ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};

  // destination codes on chosen_pool
  localparam logic POOL_A = 1'b0;
  localparam logic POOL_B = 1'b1;

  // one registered request, products already formed
  typedef struct packed {
    logic                     a_up;
    logic                     b_up;
    logic [PROD_W-1:0]        add_a;
    logic [PROD_W-1:0]        sub_b;
    logic signed [DIFF_W-1:0] diff;
  } step_t;

endpackage

// ===== rtl/wtrs_if.sv =====
interface wtrs_in_if;
  import wtrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                pool_a_up;
  logic                pool_b_up;

  modport source (output valid, weight, pool_a_up, pool_b_up, input ready);
  modport sink   (input valid, weight, pool_a_up, pool_b_up, output ready);
endinterface

interface wtrs_out_if;
  logic valid;
  logic ready;
  logic chosen_pool;
  logic both_down;

  modport source (output valid, chosen_pool, both_down, input ready);
  modport sink   (input valid, chosen_pool, both_down, output ready);
endinterface

// ===== rtl/wtrs_tracker.sv =====
module wtrs_tracker import wtrs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  step_t step_i,
  output logic  pick_a
);

  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [CMP_W-1:0]  near_sum;
  logic signed [DIFF_W-1:0] delta;
  logic signed [ERR_W:0]    sum;

  // near zero the error fits in 42 bits; compare 2*E + diff against zero
  assign near_sum = $signed({err_r[CMP_W-2:0], 1'b0})
                  + $signed({{(CMP_W-DIFF_W){step_i.diff[DIFF_W-1]}}, step_i.diff});

  always_comb begin
    if (step_i.a_up && !step_i.b_up) begin
      pick_a = 1'b1;
    end else if (!step_i.a_up && step_i.b_up) begin
      pick_a = 1'b0;
    end else if (err_r <= -ERR_BOUND) begin
      pick_a = 1'b1;
    end else if (err_r >= ERR_BOUND) begin
      pick_a = 1'b0;
    end else begin
      pick_a = (near_sum <= 0);
    end
  end

  // error moves by the chosen share, saturating at the signed limits
  assign delta = pick_a ? $signed({1'b0, step_i.add_a}) : -$signed({1'b0, step_i.sub_b});
  assign sum   = $signed({err_r[ERR_W-1], err_r})
               + $signed({{(ERR_W+1-DIFF_W){delta[DIFF_W-1]}}, delta});

  always_comb begin
    if (sum[ERR_W] != sum[ERR_W-1]) begin
      err_nxt = sum[ERR_W] ? ERR_MIN : ERR_MAX;
    end else begin
      err_nxt = sum[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
    end else if (step) begin
      err_r <= err_nxt;
    end
  end

  a_only_a_up: assert property (@(posedge clk) disable iff (!rst_n)
    step && step_i.a_up && !step_i.b_up |-> pick_a)
    else $error("request with only A up not sent to A");

  a_only_b_up: assert property (@(posedge clk) disable iff (!rst_n)
    step && !step_i.a_up && step_i.b_up |-> !pick_a)
    else $error("request with only B up not sent to B");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(err_r))
    else $error("tracking error moved without a request");

endmodule

// ===== rtl/weighted_two_way_ratio_splitter.sv =====
// Channel   Dir  Beat payload                         Handshake
// in_bus    in   weight[31:0], pool_a_up, pool_b_up   valid/ready
// out_bus   out  chosen_pool, both_down               valid/ready
// cfg_*     in   cfg_wdata[6:0] = ratio_percent       cfg_we, no wait
//
// One beat per cycle sustained while out_bus takes every result. A request is
// registered with its two share products at the accepting edge; its result
// is loaded into the result register when the input stage advances, and the
// tracking error register is updated at that same edge. That error register
// is the only loop, closed by the decision compare and a 64-bit saturating add.
// Reset (rst_n low, synchronous) clears the error and sets the ratio to 50.
// A stall on out_bus holds both stages; in_bus stays ready while the input
// stage can move on.
module weighted_two_way_ratio_splitter import wtrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  wtrs_in_if.sink            in_bus,
  wtrs_out_if.source         out_bus,
  input  logic               cfg_we,
  input  logic [RATIO_W-1:0] cfg_wdata
);

  logic [RATIO_W-1:0]  ratio_r;
  logic [RATIO_W-1:0]  ratio_eff;
  logic [WEIGHT_W-1:0] w_eff;
  logic [PROD_W-1:0]   add_a;
  logic [PROD_W-1:0]   sub_b;

  step_t step_r;
  logic  s1_valid_r;
  logic  s1_adv;
  logic  in_take;
  logic  pick_a;

  logic out_valid_r;
  logic chosen_r;
  logic both_down_r;

  // ratio register; values above one hundred act as one hundred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
    end else if (cfg_we) begin
      ratio_r <= cfg_wdata;
    end
  end

  assign ratio_eff = (ratio_r > RATIO_FULL) ? RATIO_FULL : ratio_r;

  // zero weight counts as one
  assign w_eff = (in_bus.weight == '0) ? WEIGHT_W'(1) : in_bus.weight;
  assign add_a = PROD_W'(w_eff) * PROD_W'(RATIO_FULL - ratio_eff);
  assign sub_b = PROD_W'(w_eff) * PROD_W'(ratio_eff);

  // advance the input stage when the result register is free or draining
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      step_r.a_up  <= in_bus.pool_a_up;
      step_r.b_up  <= in_bus.pool_b_up;
      step_r.add_a <= add_a;
      step_r.sub_b <= sub_b;
      step_r.diff  <= $signed({1'b0, add_a}) - $signed({1'b0, sub_b});
    end
  end

  wtrs_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .step_i (step_r),
    .pick_a (pick_a)
  );

  // result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      chosen_r    <= pick_a ? POOL_A : POOL_B;
      both_down_r <= !step_r.a_up && !step_r.b_up;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.chosen_pool = chosen_r;
  assign out_bus.both_down   = both_down_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input stage dropped a beat while stalled");

  a_adv_loads: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat missing from result register");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_eff <= RATIO_FULL)
    else $error("effective ratio above one hundred");

endmodule

// ===== test/weighted_two_way_ratio_splitter_test.sv =====
`timescale 1ns / 1ps

module weighted_two_way_ratio_splitter_test import wtrs_pkg::*;;

  // Expected routing of one request.
  typedef struct {
    logic chosen_pool;
    logic both_down;
  } route_t;

  // Scoreboard: tracks the ratio register and the tracking error, turns each
  // accepted request into its expected route and checks routes in order.
  class route_scoreboard;
    logic [RATIO_W-1:0] ratio_reg;
    longint             track_err;
    route_t             routes_due[$];
    int                 fails;

    function void clear();
      ratio_reg = RATIO_RESET;
      track_err = 0;
      routes_due.delete();
    endfunction

    function void set_ratio(logic [RATIO_W-1:0] value);
      ratio_reg = value;
    endfunction

    function int pending();
      return routes_due.size();
    endfunction

    function void flag(string what);
      fails++;
      if (fails <= 10) $display("%t %s", $realtime, what);
    endfunction

    // Add with clamp at the signed 64-bit limits.
    function longint clamp_add(longint base, longint delta);
      logic signed [ERR_W:0] sum;
      sum = base;
      sum = sum + delta;
      if (sum > ERR_MAX) return ERR_MAX;
      if (sum < ERR_MIN) return ERR_MIN;
      return longint'(sum);
    endfunction

    function void note_request(logic [WEIGHT_W-1:0] weight, logic a_up, logic b_up);
      longint full;
      longint w;
      longint r;
      bit     pick_a;
      route_t rt;
      full = RATIO_FULL;
      w = (weight == '0) ? 64'sd1 : longint'({32'b0, weight});
      r = (ratio_reg > RATIO_FULL) ? full : longint'({57'b0, ratio_reg});
      if (a_up && !b_up) begin
        pick_a = 1'b1;
      end else if (!a_up && b_up) begin
        pick_a = 1'b0;
      end else if (track_err <= -ERR_BOUND) begin
        pick_a = 1'b1;
      end else if (track_err >= ERR_BOUND) begin
        pick_a = 1'b0;
      end else begin
        // ties go to A
        pick_a = (2 * track_err + w * (full - 2 * r)) <= 0;
      end
      track_err = pick_a ? clamp_add(track_err, w * (full - r))
                         : clamp_add(track_err, -(w * r));
      rt.chosen_pool = pick_a ? POOL_A : POOL_B;
      rt.both_down   = !a_up && !b_up;
      routes_due.push_back(rt);
    endfunction

    function void check_result(logic chosen_pool, logic both_down);
      route_t rt;
      if (routes_due.size() == 0) begin
        flag($sformatf("unexpected route beat: chosen_pool=%0b both_down=%0b",
                       chosen_pool, both_down));
        return;
      end
      rt = routes_due.pop_front();
      if (chosen_pool !== rt.chosen_pool)
        flag($sformatf("chosen_pool mismatch: expected %0b, got %0b",
                       rt.chosen_pool, chosen_pool));
      if (both_down !== rt.both_down)
        flag($sformatf("both_down mismatch: expected %0b, got %0b",
                       rt.both_down, both_down));
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 55;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [RATIO_W-1:0] cfg_wdata;

  wtrs_in_if  in_bus();
  wtrs_out_if out_bus();

  route_scoreboard sb = new();

  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned cycle_count = 0;

  weighted_two_way_ratio_splitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: drop ready at random, at the rate of the current idling mode.
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: values read here are the ones from before the edge, since every
  // driver updates through nonblocking assignments.
  always @(posedge clk) begin
    if (!rst_n) begin
      sb.clear();
    end else begin
      if (cfg_we) sb.set_ratio(cfg_wdata);
      if (in_bus.valid && in_bus.ready)
        sb.note_request(in_bus.weight, in_bus.pool_a_up, in_bus.pool_b_up);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.chosen_pool, out_bus.both_down);
    end
  end

  // Offer one request beat after a random gap; return at the edge that takes it.
  // Valid stays high on return so back-to-back beats need no extra edge.
  task automatic send_request(input logic [WEIGHT_W-1:0] weight,
                              input logic a_up, input logic b_up);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.weight    <= weight;
    in_bus.pool_a_up <= a_up;
    in_bus.pool_b_up <= b_up;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Close a burst and wait until every route beat has come back.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the ratio register with the block idle.
  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly moderate weights so the error stays near zero and the ratio rule
  // gets exercised; full-range and extreme weights push toward the bounds.
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 255);
      3:       return $urandom_range(0, 65535);
      4:       return $urandom_range(0, 1) ? {WEIGHT_W{1'b1}} : '0;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_gap_pct = 38;
        stall_pct    = 81;
      end
      1: begin
        send_gap_pct = 81;
        stall_pct    = 38;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
    endcase
  endtask

  initial begin
    logic [RATIO_W-1:0] ratio_plan [6];
    logic [RATIO_W-1:0] ratio;
    int                 phase;

    ratio_plan = '{7'd50, 7'd0, 7'd100, 7'd127, 7'd1, 7'd99};
    sb.fails         = 0;
    sb.clear();
    set_idling(0);
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.weight    <= '0;
    in_bus.pool_a_up <= 1'b0;
    in_bus.pool_b_up <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset ratio: weight extremes, zero weight, all four up/down combinations.
    send_request('0, 1'b1, 1'b1);
    send_request({WEIGHT_W{1'b1}}, 1'b1, 1'b1);
    send_request(32'd1, 1'b1, 1'b0);
    send_request({WEIGHT_W{1'b1}}, 1'b0, 1'b1);
    send_request('0, 1'b0, 1'b0);
    send_request(32'd7, 1'b0, 1'b0);

    // Ratio zero with A forced: drive the error past the upper bound, then
    // both-up must go to B.
    write_ratio(7'd0);
    repeat (4) send_request({WEIGHT_W{1'b1}}, 1'b1, 1'b0);
    send_request({WEIGHT_W{1'b1}}, 1'b1, 1'b1);
    send_request('0, 1'b0, 1'b0);

    // Full ratio with B forced: swing the error below the lower bound, then
    // both-up must go to A.
    write_ratio(7'd100);
    repeat (8) send_request({WEIGHT_W{1'b1}}, 1'b0, 1'b1);
    send_request(32'd5, 1'b1, 1'b1);
    send_request({WEIGHT_W{1'b1}}, 1'b0, 1'b0);

    // Out-of-range ratio saturates to one hundred.
    write_ratio(7'd127);
    send_request(32'd3, 1'b1, 1'b1);
    send_request('0, 1'b0, 1'b0);

    // Random phases: three per idling mode, each under its own ratio.
    for (phase = 0; phase < 9; phase++) begin
      ratio = (phase < 6) ? ratio_plan[phase] : 7'($urandom_range(0, 127));
      write_ratio(ratio);
      set_idling(phase / 3);
      repeat (PHASE_ITEMS)
        send_request(pick_weight(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.pending() != 0) sb.flag("route beats missing at end of run");
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
